// File: sv/deq_pkg.sv
// ============================================================================
// deq_pkg
// Shared types and constants for the double-ended queue.
// ============================================================================
package deq_pkg;

    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SIZE       = 3'd4,
        OP_EMPTY      = 3'd5,
        OP_PEEK_FRONT = 3'd6,
        OP_PEEK_BACK  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;     // capture the incoming item
        logic push;        // write the word and move an index
        logic out_direct;  // load the result computed from registers
        logic out_mem;     // load the result from store read data, retire a pop
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic out_busy;    // result register holds an item not taken this cycle
    } dp_stat_t;

endpackage

// File: sv/deq_ctrl.sv
// ============================================================================
// deq_ctrl
// Sequencer: accepts one item, executes it, waits on the store read if needed.
// ============================================================================
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  deq_pkg::dp_stat_t stat,
    output deq_pkg::cmd_t     cmd
);
    import deq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   is_push;
    logic   needs_read;

    assign is_push = (stat.op == OP_PUSH_FRONT) || (stat.op == OP_PUSH_BACK);
    assign needs_read = !stat.empty &&
                        ((stat.op == OP_POP_FRONT) || (stat.op == OP_POP_BACK) ||
                         (stat.op == OP_PEEK_FRONT) || (stat.op == OP_PEEK_BACK));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (is_push && !stat.full)
                begin
                    state_next = S_IDLE;
                end
                else if (needs_read)
                begin
                    state_next = S_READ;
                end
                else if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_in  = in_valid;
            end
            S_EXEC:
            begin
                if (is_push && !stat.full)
                begin
                    cmd.push = 1'b1;
                end
                else if (!needs_read && !stat.out_busy)
                begin
                    cmd.out_direct = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.out_mem = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/deq_dp.sv
// ============================================================================
// deq_dp
// Datapath: ring store, head/tail indices, count and the result register.
// ============================================================================
module deq_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [2:0]              operation,
    input  logic signed [31:0]      value,
    input  deq_pkg::cmd_t           cmd,
    output deq_pkg::dp_stat_t       stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      answer,
    output logic [1:0]              status
);
    import deq_pkg::*;

    logic [WORD_W-1:0] store_mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    op_t               op_reg;
    logic [WORD_W-1:0] word_reg;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] answer_reg;
    status_t           status_reg;

    logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              is_empty, is_full;
    logic [WORD_W-1:0] direct_answer;
    status_t           direct_status;

    // ring index neighbors, wrap at DEPTH
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_W'(DEPTH - 1) : tail_reg - 1'b1;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    assign rd_addr = ((op_reg == OP_POP_BACK) || (op_reg == OP_PEEK_BACK)) ? tail_dec : head_reg;
    assign wr_addr = (op_reg == OP_PUSH_FRONT) ? head_dec : tail_reg;

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            store_mem[wr_addr] <= word_reg;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= op_t'(operation);
            word_reg <= value;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
            if (op_reg == OP_PUSH_FRONT)
            begin
                head_next = head_dec;
            end
            else
            begin
                tail_next = tail_inc;
            end
        end
        else if (cmd.out_mem)
        begin
            if (op_reg == OP_POP_FRONT)
            begin
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
            end
            else if (op_reg == OP_POP_BACK)
            begin
                tail_next  = tail_dec;
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // results that need no store read
    always_comb
    begin
        direct_answer = '1;
        direct_status = STS_EMPTY;
        case (op_reg)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                direct_answer = '0;
                direct_status = STS_FULL;
            end
            OP_SIZE:
            begin
                direct_answer = WORD_W'(count_reg);
                direct_status = STS_OK;
            end
            OP_EMPTY:
            begin
                direct_answer = WORD_W'(is_empty);
                direct_status = STS_OK;
            end
            default:
            begin
                direct_answer = '1;
                direct_status = STS_EMPTY;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_direct || cmd.out_mem)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_direct)
        begin
            answer_reg <= direct_answer;
            status_reg <= direct_status;
        end
        else if (cmd.out_mem)
        begin
            answer_reg <= rdata_reg;
            status_reg <= STS_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

    assign stat.op       = op_reg;
    assign stat.full     = is_full;
    assign stat.empty    = is_empty;
    assign stat.out_busy = out_valid_reg && !out_ready;

endmodule

// File: sv/double_ended_queue.sv
// Sequencing: an accepted item is captured, then executed; pops and peeks of a non-empty
//   deque add a registered store read before the result loads. A push that fits gives no result.
// The block takes no new item until the previous one has finished (pushes, size, empty,
//   dropped or empty ops in EXEC, pops and peeks in READ) and stalls while a result waits.
// Reset (rst_n, async, active low): deque empty, no result pending; store contents
//   are not cleared, and only store data at live elements is used for a result.
// ============================================================================
// double_ended_queue
// Bounded deque of signed 32-bit words in a ring store with a sequencer.
// ============================================================================
module double_ended_queue (
    input  logic               clk,
    input  logic               rst_n,
    // input item channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    // result item channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] answer,
    output logic [1:0]         status
);
    import deq_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    // Sequencer: IDLE takes an item, EXEC either commits a push, produces a
    // register-only result, or starts a store read that READ then retires.
    // The result register is separate, so the sequencer only stalls when a
    // new result is ready while the previous one has not been taken.
    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: ring store, head/tail/count and the result register.
    deq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .answer    (answer),
        .status    (status)
    );

endmodule

// File: bench/double_ended_queue_check.sv
// ============================================================================
// double_ended_queue_check
// Watches both item channels, mirrors the deque and compares every result.
// ============================================================================
module double_ended_queue_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] answer,
    input  logic [1:0]         status,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import deq_pkg::*;

    localparam int REPLY_SLOTS = 16;

    typedef struct packed {
        logic signed [WORD_W-1:0] answer;
        status_t                  status;
    } deq_reply_t;

    // mirror of the deque; back_idx points one past the back element
    logic signed [WORD_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0]         front_idx = '0;
    logic [IDX_W-1:0]         back_idx = '0;
    logic [CNT_W-1:0]         held = '0;

    // expected results, oldest at reply_rd
    deq_reply_t               reply_slots [REPLY_SLOTS];
    logic [3:0]               reply_wr = '0;
    logic [3:0]               reply_rd = '0;
    int                       reply_count = 0;

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic logic [IDX_W-1:0] ring_fwd(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_back(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // apply one accepted item to the mirror, queue the result it causes
    function automatic void predict_op(input op_t op, input logic signed [WORD_W-1:0] word);
        deq_reply_t r;
        bit         gives_reply;
        r.answer = '0;
        r.status = STS_OK;
        gives_reply = 1'b1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held >= CNT_W'(DEPTH))
                    r.status = STS_FULL;
                else
                begin
                    gives_reply = 1'b0;
                    if (op == OP_PUSH_FRONT)
                    begin
                        front_idx = ring_back(front_idx);
                        ring_words[front_idx] = word;
                    end
                    else
                    begin
                        ring_words[back_idx] = word;
                        back_idx = ring_fwd(back_idx);
                    end
                    held = held + 1'b1;
                end
            end
            OP_SIZE:
                r.answer = WORD_W'(held);
            OP_EMPTY:
                r.answer = (held == '0) ? 1 : 0;
            default:
            begin
                if (held == '0)
                begin
                    r.answer = -1;
                    r.status = STS_EMPTY;
                end
                else
                begin
                    case (op)
                        OP_POP_FRONT:
                        begin
                            r.answer = ring_words[front_idx];
                            front_idx = ring_fwd(front_idx);
                            held = held - 1'b1;
                        end
                        OP_POP_BACK:
                        begin
                            back_idx = ring_back(back_idx);
                            r.answer = ring_words[back_idx];
                            held = held - 1'b1;
                        end
                        OP_PEEK_FRONT:
                            r.answer = ring_words[front_idx];
                        default:
                            r.answer = ring_words[ring_back(back_idx)];
                    endcase
                end
            end
        endcase
        if (gives_reply)
        begin
            reply_slots[reply_wr] = r;
            reply_wr = reply_wr + 1'b1;
            reply_count++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t deque mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        deq_reply_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_op(op_t'(operation), value);
                if (reply_count > REPLY_SLOTS)
                    report_mismatch("result backlog overflow");
            end
            if (out_valid && out_ready)
            begin
                if (reply_count == 0)
                    report_mismatch($sformatf("unexpected result answer=%0d status=%0d",
                                              answer, status));
                else
                begin
                    want = reply_slots[reply_rd];
                    reply_rd = reply_rd + 1'b1;
                    reply_count--;
                    if (answer !== want.answer)
                        report_mismatch($sformatf("answer %0d, want %0d",
                                                  answer, want.answer));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  status, want.status));
                end
            end
        end
        outstanding <= reply_count;
    end

endmodule

// File: bench/double_ended_queue_test.sv
// ============================================================================
// double_ended_queue_test
// Drives operation items into the deque with random gaps and output stalls;
// a checker beside the block mirrors the deque and compares every result.
// ============================================================================
module double_ended_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import deq_pkg::*;

    // receiver holds off right after reset, so the single
    // result register fills and the block backs up its input channel
    localparam int HOLD_OFF = 200;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] answer;
    logic [1:0]         status;
    int                 fail_count;
    int                 outstanding;
    // set during a stretch where neither side idles
    bit                 calm = 1'b0;

    always #6 clk = ~clk;

    double_ended_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .answer    (answer),
        .status    (status)
    );

    double_ended_queue_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .answer      (answer),
        .status      (status),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    // Offer one item. Called at a falling edge; returns at the falling edge
    // after acceptance with valid still high, so the next call either keeps
    // it high or drops it for a gap - never both in one step.
    task automatic send_item(input op_t op, input logic signed [31:0] word);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= word;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Random mix: push_pct percent pushes (either end), the rest spread over
    // pops, peeks, size and empty. Value is random for every op; non-push
    // ops must ignore it.
    task automatic random_items(input int n, input int push_pct);
        op_t op;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = op_t'($urandom_range(OP_POP_FRONT, OP_PEEK_BACK));
            send_item(op, $urandom);
        end
    endtask

    // Result side: long hold-off first, then ready drops about 15% of the
    // cycles except during the calm stretch.
    initial
    begin : receiver
        out_ready = 1'b0;
        @(posedge rst_n);
        repeat (HOLD_OFF) @(negedge clk);
        forever
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= 15);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_SIZE;
        value     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every pop and peek on the empty deque, then size/empty at zero
        send_item(OP_POP_FRONT, 32'sd5);
        send_item(OP_POP_BACK, -32'sd5);
        send_item(OP_PEEK_FRONT, 32'sd0);
        send_item(OP_PEEK_BACK, -32'sd1);
        send_item(OP_SIZE, 32'sh7fffffff);
        send_item(OP_EMPTY, 32'sh80000000);
        // push front from index zero wraps the head to the top of the ring
        send_item(OP_PUSH_FRONT, 32'sh7fffffff);
        send_item(OP_PUSH_BACK, 32'sh80000000);
        send_item(OP_PUSH_FRONT, -32'sd1);
        send_item(OP_PUSH_BACK, 32'sd0);
        send_item(OP_PEEK_FRONT, 32'sd0);
        send_item(OP_PEEK_BACK, 32'sd0);
        send_item(OP_SIZE, 32'sd0);
        send_item(OP_EMPTY, 32'sd0);
        send_item(OP_POP_BACK, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        // pop back the last element, then pop back again on the empty deque
        send_item(OP_POP_BACK, 32'sd0);
        send_item(OP_POP_BACK, 32'sd0);
        send_item(OP_EMPTY, 32'sd0);
        send_item(OP_PUSH_BACK, 32'sh55555555);
        send_item(OP_PUSH_FRONT, 32'shaaaaaaaa);
        send_item(OP_PEEK_BACK, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);

        // general mix at shallow occupancy
        random_items(60, 45);

        // fill to the limit plus a few pushes that must be dropped as full,
        // with neither side idling
        calm = 1'b1;
        random_items(DEPTH + 4, 100);
        calm = 1'b0;

        // hover around full: drops, peeks and pops against a full ring
        random_items(30, 50);
        // mostly pops and peeks from both ends
        random_items(30, 10);
        in_valid <= 1'b0;

        // wait for the last expected result, then keep running to catch strays
        while (outstanding != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (fail_count == 0)
            $display("double_ended_queue_test: done, clean");
        else
            $display("double_ended_queue_test: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin : watchdog
        #3ms;
        $display("double_ended_queue_test: done, errors");
        $finish;
    end

endmodule
